// ===== src/tmse_pkg.sv =====
// Shared types and codes for the Turing machine step engine.
// Holds the beat layouts, the rule word, and the step result bundle.
// No dependencies.
package tmse_pkg;

  typedef enum logic [2:0] {
    CMD_LOAD_RULE = 3'd0,
    CMD_SET_HALT  = 3'd1,
    CMD_WR_TAPE   = 3'd2,
    CMD_START     = 3'd3,
    CMD_STEP      = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    MV_LEFT  = 2'd0,
    MV_STAY  = 2'd1,
    MV_RIGHT = 2'd2,
    MV_BAD   = 2'd3
  } move_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_RULE  = 2'd1,
    ST_BAD_DIR  = 2'd2,
    ST_OFF_TAPE = 2'd3
  } status_t;

  // Rule word: valid, symbol to write, next state, head move
  typedef struct packed {
    logic       valid;
    logic [3:0] new_symbol;
    logic [5:0] new_state;
    move_t      move;
  } rule_t;

  localparam int RULE_W = $bits(rule_t);

  // Input beat payload, last member in the lowest bits
  typedef struct packed {
    logic [3:0]  pad;
    logic [11:0] position;
    logic        halt_mark;
    logic [1:0]  move;
    logic [5:0]  new_state;
    logic [3:0]  new_symbol;
    logic        rule_valid;
    logic [3:0]  sel_symbol;
    logic [5:0]  sel_state;
  } in_fields_t;

  // Result beat payload, last member in the lowest bits
  typedef struct packed {
    logic [6:0]  pad;
    status_t     status;
    logic        halted;
    logic [31:0] step_count;
    logic [3:0]  rd_symbol;
    logic [11:0] head_position;
    logic [5:0]  current_state;
  } out_fields_t;

  // Outcome of one step evaluation
  typedef struct packed {
    logic        commit;
    status_t     status;
    logic [11:0] head_nxt;
    logic        tape_we;
    logic [3:0]  tape_sym;
    logic [5:0]  state_nxt;
  } step_res_t;

endpackage

// ===== src/tmse_ram.sv =====
// Generic single-clock RAM: one write port, one registered read port.
// Read-first when both ports hit the same address. No dependencies.
module tmse_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/tmse_step.sv =====
// Step evaluation: picks the specific or wildcard rule, checks the move,
// and builds the commit bundle. Depends on tmse_pkg.
module tmse_step #(
  parameter int TAPE_CELLS = 4096
) (
  input  tmse_pkg::rule_t     spec_rule,
  input  logic                spec_hit,
  input  tmse_pkg::rule_t     wild_rule,
  input  logic                state_ok,
  input  logic [11:0]         head,
  input  logic [5:0]          state,
  output tmse_pkg::step_res_t res
);
  import tmse_pkg::*;

  rule_t rule;
  logic  use_spec;
  logic  have_rule;

  // Choose the rule: specific one when present, else the wildcard
  assign use_spec  = spec_hit & spec_rule.valid;
  assign rule      = use_spec ? spec_rule : wild_rule;
  assign have_rule = use_spec | (state_ok & wild_rule.valid);

  // Check the move and form the next head
  always_comb begin
    res.status   = ST_OK;
    res.head_nxt = head;
    if (!have_rule) begin
      res.status = ST_NO_RULE;
    end else begin
      case (rule.move)
        MV_LEFT: begin
          if (head == 12'd0) res.status = ST_OFF_TAPE;
          else res.head_nxt = head - 12'd1;
        end
        MV_RIGHT: begin
          if ((32'(head) + 32'd1) >= 32'(TAPE_CELLS)) res.status = ST_OFF_TAPE;
          else res.head_nxt = head + 12'd1;
        end
        MV_STAY: res.head_nxt = head;
        default: res.status = ST_BAD_DIR;
      endcase
    end
    res.commit    = (res.status == ST_OK);
    res.tape_we   = res.commit && (rule.new_symbol != 4'd0);
    res.tape_sym  = rule.new_symbol;
    res.state_nxt = (rule.new_state != 6'd0) ? rule.new_state : state;
  end

endmodule

// ===== src/turing_machine_step_engine.sv =====
// Turing machine step engine, top level: sequencer, machine registers and
// the rule, tape and halt-mark RAMs. Depends on tmse_pkg, tmse_ram, tmse_step.
//
// After reset the block runs a clearing pass that zeroes all three memories
// and accepts no beat meanwhile; blank symbol writes are taken at any time.
// One item is worked on at a time. For a step command the tape cell under
// the head, the specific rule and the wildcard rule are read one after
// another from single-read-port RAMs, the step commits, and the halt mark of
// the new state is read back before the result is registered. Every other
// command commits at acceptance, then reads the halt mark and registers the
// result. A result waiting in the output register does not block acceptance
// of the next beat; it only holds the following item in its result state
// until it is taken.
module turing_machine_step_engine #(
  parameter int STATE_COUNT = 64,
  parameter int NUM_SYMBOLS = 16,
  parameter int TAPE_CELLS  = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  // blank symbol register
  input  logic        cfg_we,
  input  logic [3:0]  cfg_wdata,
  // in_tdata fields from bit 0: sel_state, sel_symbol, rule_valid, new_symbol,
  // new_state, move, halt_mark, position, zero pad
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,
  // in_tuser fields from bit 0: cmd
  input  logic [2:0]  in_tuser,
  // out_tdata fields from bit 0: current_state, head_position, rd_symbol,
  // step_count, halted, status, zero pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata
);
  import tmse_pkg::*;

  localparam int RULE_DEPTH = STATE_COUNT * NUM_SYMBOLS;
  localparam int RAW        = $clog2(RULE_DEPTH);
  localparam int TAW        = $clog2(TAPE_CELLS);
  localparam int HAW        = $clog2(STATE_COUNT);
  localparam int CLR_DEPTH  = (RULE_DEPTH > TAPE_CELLS) ? RULE_DEPTH : TAPE_CELLS;
  localparam int CLW        = $clog2(CLR_DEPTH);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_SPEC, S_WILD, S_EXEC, S_HWAIT, S_RESP
  } seq_t;

  seq_t        seq_r, seq_nxt;
  logic [CLW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [5:0]  state_r, state_nxt;
  logic [11:0] head_r, head_nxt;
  logic [31:0] steps_r, steps_nxt;
  logic [3:0]  rd_r, rd_nxt;
  status_t     status_r, status_nxt;
  logic        spec_hit_r, spec_hit_nxt;
  rule_t       spec_rule_r, spec_rule_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_fields_t out_r, out_nxt;
  logic [3:0]  blank_r;

  in_fields_t  in_f;
  cmd_t        cmd;
  logic        accept;
  logic        state_ok;
  logic [3:0]  rd_sym;
  step_res_t   step_res;

  logic            rule_we;
  logic [RAW-1:0]  rule_waddr, rule_raddr;
  logic [RULE_W-1:0] rule_wdata, rule_rdata;
  logic            tape_we;
  logic [TAW-1:0]  tape_waddr;
  logic [3:0]      tape_wdata, tape_rdata;
  logic            halt_we;
  logic [HAW-1:0]  halt_waddr;
  logic            halt_wdata, halt_rdata;

  // Flat rule index of a state and symbol pair
  function automatic logic [31:0] rule_index(input logic [5:0] st, input logic [3:0] sym);
    rule_index = 32'(st) * 32'(NUM_SYMBOLS) + 32'(sym);
  endfunction

  assign in_f      = in_fields_t'(in_tdata);
  assign cmd       = cmd_t'(in_tuser);
  assign in_tready = (seq_r == S_IDLE);
  assign accept    = in_tvalid & in_tready;
  assign state_ok  = 32'(state_r) < 32'(STATE_COUNT);

  // Symbol under the head; an unwritten cell reads as blank
  assign rd_sym = (tape_rdata != 4'd0) ? tape_rdata : blank_r;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blank_r <= 4'd1;
    end else if (cfg_we) begin
      blank_r <= cfg_wdata;
    end
  end

  // Rule memory ports
  always_comb begin
    rule_we    = 1'b0;
    rule_waddr = RAW'(clr_cnt_r);
    rule_wdata = '0;
    if (seq_r == S_CLEAR) begin
      rule_we = 1'b1;
    end else if (accept && cmd == CMD_LOAD_RULE &&
                 32'(in_f.sel_state) < 32'(STATE_COUNT) &&
                 32'(in_f.sel_symbol) < 32'(NUM_SYMBOLS)) begin
      rule_we    = 1'b1;
      rule_waddr = RAW'(rule_index(in_f.sel_state, in_f.sel_symbol));
      rule_wdata = {in_f.rule_valid, in_f.new_symbol, in_f.new_state, in_f.move};
    end
    if (seq_r == S_SPEC) rule_raddr = RAW'(rule_index(state_r, rd_sym));
    else rule_raddr = RAW'(rule_index(state_r, 4'd0));
  end

  // Tape memory ports; the read always follows the head
  always_comb begin
    tape_we    = 1'b0;
    tape_waddr = TAW'(clr_cnt_r);
    tape_wdata = 4'd0;
    if (seq_r == S_CLEAR) begin
      tape_we = 1'b1;
    end else if (seq_r == S_EXEC && step_res.tape_we) begin
      tape_we    = 1'b1;
      tape_waddr = TAW'(head_r);
      tape_wdata = step_res.tape_sym;
    end else if (accept && cmd == CMD_WR_TAPE &&
                 32'(in_f.position) < 32'(TAPE_CELLS)) begin
      tape_we    = 1'b1;
      tape_waddr = TAW'(in_f.position);
      tape_wdata = in_f.sel_symbol;
    end
  end

  // Halt mark ports; the read always follows the current state
  always_comb begin
    halt_we    = 1'b0;
    halt_waddr = HAW'(clr_cnt_r);
    halt_wdata = 1'b0;
    if (seq_r == S_CLEAR) begin
      halt_we = 1'b1;
    end else if (accept && cmd == CMD_SET_HALT &&
                 32'(in_f.sel_state) < 32'(STATE_COUNT)) begin
      halt_we    = 1'b1;
      halt_waddr = HAW'(in_f.sel_state);
      halt_wdata = in_f.halt_mark;
    end
  end

  tmse_ram #(.WIDTH(RULE_W), .DEPTH(RULE_DEPTH)) u_rule_ram (
    .clk   (clk),
    .we    (rule_we),
    .waddr (rule_waddr),
    .wdata (rule_wdata),
    .raddr (rule_raddr),
    .rdata (rule_rdata)
  );

  tmse_ram #(.WIDTH(4), .DEPTH(TAPE_CELLS)) u_tape_ram (
    .clk   (clk),
    .we    (tape_we),
    .waddr (tape_waddr),
    .wdata (tape_wdata),
    .raddr (TAW'(head_r)),
    .rdata (tape_rdata)
  );

  tmse_ram #(.WIDTH(1), .DEPTH(STATE_COUNT)) u_halt_ram (
    .clk   (clk),
    .we    (halt_we),
    .waddr (halt_waddr),
    .wdata (halt_wdata),
    .raddr (HAW'(state_r)),
    .rdata (halt_rdata)
  );

  tmse_step #(.TAPE_CELLS(TAPE_CELLS)) u_step (
    .spec_rule (spec_rule_r),
    .spec_hit  (spec_hit_r),
    .wild_rule (rule_t'(rule_rdata)),
    .state_ok  (state_ok),
    .head      (head_r),
    .state     (state_r),
    .res       (step_res)
  );

  // Sequencer next state
  always_comb begin
    seq_nxt       = seq_r;
    clr_cnt_nxt   = clr_cnt_r;
    state_nxt     = state_r;
    head_nxt      = head_r;
    steps_nxt     = steps_r;
    rd_nxt        = rd_r;
    status_nxt    = status_r;
    spec_hit_nxt  = spec_hit_r;
    spec_rule_nxt = spec_rule_r;
    out_valid_nxt = out_valid_r & ~out_tready;
    out_nxt       = out_r;
    case (seq_r)
      S_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == CLW'(CLR_DEPTH - 1)) seq_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          rd_nxt     = 4'd0;
          status_nxt = ST_OK;
          seq_nxt    = S_HWAIT;
          if (cmd == CMD_STEP) begin
            seq_nxt = S_SPEC;
          end else if (cmd == CMD_START &&
                       32'(in_f.sel_state) < 32'(STATE_COUNT) &&
                       32'(in_f.position) < 32'(TAPE_CELLS)) begin
            state_nxt = in_f.sel_state;
            head_nxt  = in_f.position;
            steps_nxt = 32'd0;
          end
        end
      end
      // Tape data is here: latch the read symbol, fetch the specific rule
      S_SPEC: begin
        rd_nxt       = rd_sym;
        spec_hit_nxt = state_ok && (32'(rd_sym) < 32'(NUM_SYMBOLS));
        seq_nxt      = S_WILD;
      end
      // Specific rule is here: hold it, fetch the wildcard
      S_WILD: begin
        spec_rule_nxt = rule_t'(rule_rdata);
        seq_nxt       = S_EXEC;
      end
      // Commit the step or report the failure
      S_EXEC: begin
        status_nxt = step_res.status;
        if (step_res.commit) begin
          state_nxt = step_res.state_nxt;
          head_nxt  = step_res.head_nxt;
          steps_nxt = steps_r + 32'd1;
        end
        seq_nxt = S_HWAIT;
      end
      S_HWAIT: seq_nxt = S_RESP;
      S_RESP: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt         = 1'b1;
          out_nxt.pad           = '0;
          out_nxt.status        = status_r;
          out_nxt.halted        = state_ok & halt_rdata;
          out_nxt.step_count    = steps_r;
          out_nxt.rd_symbol     = rd_r;
          out_nxt.head_position = head_r;
          out_nxt.current_state = state_r;
          seq_nxt               = S_IDLE;
        end
      end
      default: seq_nxt = S_IDLE;
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r       <= S_CLEAR;
      clr_cnt_r   <= '0;
      state_r     <= 6'd0;
      head_r      <= 12'd0;
      steps_r     <= 32'd0;
      out_valid_r <= 1'b0;
    end else begin
      seq_r       <= seq_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      steps_r     <= steps_nxt;
      out_valid_r <= out_valid_nxt;
    end
    rd_r        <= rd_nxt;
    status_r    <= status_nxt;
    spec_hit_r  <= spec_hit_nxt;
    spec_rule_r <= spec_rule_nxt;
    out_r       <= out_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_r;

`ifndef SYNTHESIS
  // One item at a time: an accepted beat closes the input
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_tready)
    else $error("input accepted while an item is in work");

  // A failed step commits nothing
  a_fail_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (seq_r == S_EXEC && !step_res.commit) |=>
      ($stable(state_r) && $stable(head_r) && $stable(steps_r)))
    else $error("failed step changed machine registers");

  // A step advances the count by exactly one when it commits
  a_step_count: assert property (@(posedge clk) disable iff (!rst_n)
    (seq_r == S_EXEC && step_res.commit) |=> (steps_r == $past(steps_r) + 32'd1))
    else $error("step count did not advance by one");

  // During the clearing pass the input is closed, no result is valid and only zeros reach the tape
  a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (seq_r == S_CLEAR) |-> (!in_tready && tape_wdata == 4'd0 && !out_valid_r))
    else $error("activity during clearing pass");
`endif

endmodule

// ===== tb/sv/tmse_result_checker.sv =====
`timescale 1ns / 100ps
// Result checker for the Turing machine step engine: watches the config port and
// both stream channels, predicts every result beat and compares it field by field.
// Depends on tmse_pkg for the beat layouts, command, move and status codes.
module tmse_result_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_wdata,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [39:0] in_tdata,   // sel_state, sel_symbol, rule_valid, new_symbol,
                                  // new_state, move, halt_mark, position, zero pad
  input  logic [2:0]  in_tuser,   // cmd
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [63:0] out_tdata,  // current_state, head_position, rd_symbol,
                                  // step_count, halted, status, zero pad
  output int          pending,
  output int          errors,
  output int          results,
  output int          steps_ok,
  output int          steps_bad
);
  import tmse_pkg::*;

  // Shadow copy of the machine
  rule_t       rule_mem [1024];
  logic        halt_bit [64];
  logic [3:0]  tape     [4096];
  logic [5:0]  m_state;
  logic [11:0] m_head;
  logic [31:0] m_steps;
  logic [3:0]  blank;

  out_fields_t predicted_beats [$];
  int          err_cnt;
  int          res_cnt;
  int          ok_cnt;
  int          bad_cnt;

  // Apply one accepted item to the shadow machine and return the result it gives
  function automatic out_fields_t advance_machine(logic [2:0] cmd, in_fields_t f);
    out_fields_t r;
    rule_t       rl;
    logic [3:0]  tape_val;
    logic [11:0] nh;
    r = '0;
    r.status = ST_OK;
    case (cmd)
      CMD_LOAD_RULE: begin
        rule_mem[{f.sel_state, f.sel_symbol}] =
          rule_t'({f.rule_valid, f.new_symbol, f.new_state, f.move});
      end
      CMD_SET_HALT: halt_bit[f.sel_state] = f.halt_mark;
      CMD_WR_TAPE:  tape[f.position] = f.sel_symbol;
      CMD_START: begin
        m_state = f.sel_state;
        m_head  = f.position;
        m_steps = '0;
      end
      CMD_STEP: begin
        // Read the cell, a zero cell reads as the blank symbol
        tape_val = tape[m_head];
        r.rd_symbol = (tape_val != 4'd0) ? tape_val : blank;
        // Fall back to the wildcard rule when the specific one is missing
        rl = rule_mem[{m_state, r.rd_symbol}];
        if (!rl.valid) rl = rule_mem[{m_state, 4'd0}];
        nh = m_head;
        if (!rl.valid) begin
          r.status = ST_NO_RULE;
        end else begin
          case (rl.move)
            MV_BAD:   r.status = ST_BAD_DIR;
            MV_LEFT:  if (m_head == 12'd0) r.status = ST_OFF_TAPE; else nh = m_head - 12'd1;
            MV_RIGHT: if (m_head == 12'hFFF) r.status = ST_OFF_TAPE; else nh = m_head + 12'd1;
            default: ;
          endcase
        end
        // Commit only a clean step
        if (r.status == ST_OK) begin
          if (rl.new_symbol != 4'd0) tape[m_head] = rl.new_symbol;
          if (rl.new_state != 6'd0) m_state = rl.new_state;
          m_head  = nh;
          m_steps = m_steps + 32'd1;
          ok_cnt++;
        end else begin
          bad_cnt++;
        end
      end
      default: ;
    endcase
    r.current_state = m_state;
    r.head_position = m_head;
    r.step_count    = m_steps;
    r.halted        = halt_bit[m_state];
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      err_cnt++;
      $error("%s: expected 0x%0h, got 0x%0h (result beat %0d)", name, want, got, res_cnt);
    end
  endfunction

  always @(posedge clk) begin
    out_fields_t got;
    out_fields_t want;
    if (!rst_n) begin
      for (int i = 0; i < 1024; i++) rule_mem[i] = '0;
      for (int i = 0; i < 64; i++) halt_bit[i] = 1'b0;
      for (int i = 0; i < 4096; i++) tape[i] = 4'd0;
      m_state = '0;
      m_head  = '0;
      m_steps = '0;
      blank   = 4'd1;
      predicted_beats.delete();
      err_cnt = 0;
      res_cnt = 0;
      ok_cnt  = 0;
      bad_cnt = 0;
    end else begin
      if (cfg_we) blank = cfg_wdata;
      // Retire the result beat before queueing a new prediction
      if (out_tvalid && out_tready) begin
        got = out_fields_t'(out_tdata);
        res_cnt++;
        if (predicted_beats.size() == 0) begin
          err_cnt++;
          $error("result beat %0d arrived with nothing predicted", res_cnt);
        end else begin
          want = predicted_beats.pop_front();
          check_field("current_state", 32'(want.current_state), 32'(got.current_state));
          check_field("head_position", 32'(want.head_position), 32'(got.head_position));
          check_field("rd_symbol",     32'(want.rd_symbol),     32'(got.rd_symbol));
          check_field("step_count",    want.step_count,         got.step_count);
          check_field("halted",        32'(want.halted),        32'(got.halted));
          check_field("status",        32'(want.status),        32'(got.status));
        end
      end
      if (in_tvalid && in_tready)
        predicted_beats.push_back(advance_machine(in_tuser, in_fields_t'(in_tdata)));
    end
    pending   <= predicted_beats.size();
    errors    <= err_cnt;
    results   <= res_cnt;
    steps_ok  <= ok_cnt;
    steps_bad <= bad_cnt;
  end

endmodule

// ===== tb/sv/tb_turing_machine_step_engine.sv =====
`timescale 1ns / 100ps
// Testbench top for the Turing machine step engine: clock, reset, stimulus,
// random back-pressure and the verdict. Depends on tmse_pkg and tmse_result_checker.
module tb_turing_machine_step_engine;
  import tmse_pkg::*;

  localparam int ITEMS     = 1100;
  localparam int LONG_HOLD = 400;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [3:0]  cfg_wdata;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;   // sel_state, sel_symbol, rule_valid, new_symbol,
                           // new_state, move, halt_mark, position, zero pad
  logic [2:0]  in_tuser;   // cmd
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata;  // current_state, head_position, rd_symbol,
                           // step_count, halted, status, zero pad

  int pending;
  int errors;
  int results;
  int steps_ok;
  int steps_bad;
  int sent       = 0;
  int cfg_writes = 0;
  bit send_quiet = 1'b0;

  turing_machine_step_engine DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  tmse_result_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .pending    (pending),
    .errors     (errors),
    .results    (results),
    .steps_ok   (steps_ok),
    .steps_bad  (steps_bad)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Bound the run
  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic in_fields_t noise();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return in_fields_t'(r[39:0]);
  endfunction

  function automatic in_fields_t fields(logic [5:0] st, logic [3:0] sym, logic vld,
                                        logic [3:0] nsym, logic [5:0] nst, logic [1:0] mv,
                                        logic hm, logic [11:0] pos);
    in_fields_t f;
    f = '0;
    f.sel_state  = st;
    f.sel_symbol = sym;
    f.rule_valid = vld;
    f.new_symbol = nsym;
    f.new_state  = nst;
    f.move       = mv;
    f.halt_mark  = hm;
    f.position   = pos;
    return f;
  endfunction

  // Offer one input beat after a random gap and hold it until taken
  task automatic drive_beat(logic [2:0] cmd, in_fields_t f);
    int gap;
    if ($urandom_range(0, 31) == 0) send_quiet = !send_quiet;
    gap = send_quiet ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    f.pad = '0;
    in_tvalid <= 1'b1;
    in_tdata  <= f;
    in_tuser  <= cmd;
    do @(posedge clk); while (!in_tready);
    sent++;
  endtask

  // Drop valid and wait until every predicted result has been taken
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic set_blank(logic [3:0] v);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cfg_writes++;
  endtask

  // Load a small random program over four states, seed the tape, start and step
  task automatic run_program();
    logic [5:0]  st_set [4];
    logic [11:0] origin;
    in_fields_t  f;
    int          n_steps;
    for (int i = 0; i < 4; i++) st_set[i] = 6'($urandom_range(0, 63));
    for (int i = 0; i < 4; i++) begin
      // First rule of each state is its wildcard
      for (int k = 0; k < 6; k++) begin
        f = noise();
        f.sel_state  = st_set[i];
        f.sel_symbol = (k == 0) ? 4'd0 : 4'($urandom_range(1, 15));
        f.rule_valid = ($urandom_range(0, 7) != 0);
        f.new_state  = ($urandom_range(0, 3) == 0) ? 6'd0 : st_set[$urandom_range(0, 3)];
        f.move       = ($urandom_range(0, 15) == 0) ? MV_BAD
                                                    : 2'($urandom_range(MV_LEFT, MV_RIGHT));
        drive_beat(CMD_LOAD_RULE, f);
      end
      f = noise();
      f.sel_state = st_set[i];
      f.halt_mark = ($urandom_range(0, 3) == 0);
      drive_beat(CMD_SET_HALT, f);
    end
    case ($urandom_range(0, 7))
      0:       origin = 12'($urandom_range(0, 3));
      1:       origin = 12'($urandom_range(4092, 4095));
      default: origin = 12'($urandom_range(16, 4079));
    endcase
    for (int k = 0; k < 6; k++) begin
      f = noise();
      f.position = 12'(origin + 12'($urandom_range(0, 12)) - 12'd6);
      drive_beat(CMD_WR_TAPE, f);
    end
    f = noise();
    f.sel_state = st_set[0];
    f.position  = origin;
    drive_beat(CMD_START, f);
    // Step, with a stray command now and then
    n_steps = $urandom_range(15, 40);
    for (int k = 0; k < n_steps; k++) begin
      if ($urandom_range(0, 19) == 0) drive_beat(3'($urandom_range(0, 7)), noise());
      drive_beat(CMD_STEP, noise());
    end
  endtask

  // Result sink: random stalls, quiet stretches, and one long hold-off
  initial begin : sink
    int taken;
    int wait_cyc;
    bit quiet;
    taken = 0;
    quiet = 1'b0;
    out_tready <= 1'b0;
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 31) == 0) quiet = !quiet;
      wait_cyc = quiet ? 0 : $urandom_range(0, 11);
      if (taken == 300) wait_cyc = LONG_HOLD;
      if (wait_cyc > 0) begin
        out_tready <= 1'b0;
        repeat (wait_cyc) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      taken++;
    end
  end

  initial begin : stimulus
    int prog;
    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_wdata <= '0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty machine, tape ends, wildcard, bad move, halted machine
    drive_beat(CMD_STEP, '0);
    drive_beat(CMD_LOAD_RULE, fields(6'd0, 4'd1, 1'b1, 4'd0, 6'd0, MV_LEFT, 1'b0, 12'd0));
    drive_beat(CMD_STEP, '0);
    drive_beat(CMD_START, fields(6'd0, 4'd0, 1'b0, 4'd0, 6'd0, MV_LEFT, 1'b0, 12'd4095));
    drive_beat(CMD_LOAD_RULE, fields(6'd0, 4'd1, 1'b1, 4'd15, 6'd63, MV_RIGHT, 1'b0, 12'd0));
    drive_beat(CMD_STEP, '0);
    drive_beat(CMD_LOAD_RULE, fields(6'd0, 4'd1, 1'b0, 4'd15, 6'd63, MV_RIGHT, 1'b1, 12'd0));
    drive_beat(CMD_LOAD_RULE, fields(6'd0, 4'd0, 1'b1, 4'd15, 6'd63, MV_LEFT, 1'b0, 12'd0));
    drive_beat(CMD_STEP, '0);
    drive_beat(CMD_SET_HALT, fields(6'd63, 4'd0, 1'b0, 4'd0, 6'd0, MV_LEFT, 1'b1, 12'd0));
    drive_beat(CMD_LOAD_RULE, fields(6'd63, 4'd1, 1'b1, 4'd0, 6'd0, MV_BAD, 1'b0, 12'd0));
    drive_beat(CMD_STEP, '0);
    drive_beat(CMD_LOAD_RULE, fields(6'd63, 4'd1, 1'b1, 4'd0, 6'd0, MV_RIGHT, 1'b0, 12'd0));
    drive_beat(CMD_STEP, '0);
    drive_beat(CMD_STEP, '1);
    // Writing zero makes the cell blank again
    drive_beat(CMD_WR_TAPE, fields(6'd0, 4'd0, 1'b0, 4'd0, 6'd0, MV_LEFT, 1'b0, 12'd4095));
    drive_beat(CMD_STEP, '0);
    for (int c = CMD_STEP + 1; c < 8; c++) drive_beat(3'(c), '1);
    drive_beat(CMD_LOAD_RULE, '1);
    drive_beat(CMD_SET_HALT, fields(6'd63, 4'd15, 1'b1, 4'd15, 6'd63, MV_BAD, 1'b0, 12'd4095));
    drive_beat(CMD_WR_TAPE, '1);
    // Blank symbol zero reads as the wildcard symbol
    set_blank(4'd0);
    drive_beat(CMD_START, fields(6'd0, 4'd0, 1'b0, 4'd0, 6'd0, MV_LEFT, 1'b0, 12'd2048));
    drive_beat(CMD_STEP, '0);
    set_blank(4'd15);
    drive_beat(CMD_START, '1);
    drive_beat(CMD_STEP, '0);

    // Random programs, with config changes and full drains between some of them
    prog = 0;
    while (sent < ITEMS) begin
      if (prog % 3 == 0) begin
        case ((prog / 3) % 4)
          0:       set_blank(4'd1);
          1:       set_blank(4'd15);
          2:       set_blank(4'd0);
          default: set_blank(4'($urandom_range(0, 15)));
        endcase
      end else if (prog % 3 == 1) begin
        wait_drained();
      end
      run_program();
      prog++;
    end

    wait_drained();
    repeat (20) @(posedge clk);
    $display("Ran %0d input beats over %0d programs; %0d results checked.",
             sent, prog, results);
    $display("Steps committed: %0d, steps refused: %0d, blank symbol writes: %0d.",
             steps_ok, steps_bad, cfg_writes);
    if (errors == 0 && pending == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== turing_machine_step_engine.f =====
src/tmse_pkg.sv
src/tmse_ram.sv
src/tmse_step.sv
src/turing_machine_step_engine.sv
tb/sv/tmse_result_checker.sv
tb/sv/tb_turing_machine_step_engine.sv
